FILE: src/acmac_pkg.sv
// Package for the AES-128 CMAC core: types, S-box and round helpers.
// No dependencies.
package acmac_pkg;

   localparam logic [7:0] CmacRb  = 8'h87;
   localparam logic [7:0] CmacPad = 8'h80;
   localparam int unsigned NumRounds = 10;

   typedef logic [127:0] blk_type;
   typedef logic [3:0]   rnd_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] r;
      case (x)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // round constant for the key expansion step that makes round key rnd
   function automatic logic [7:0] rcon(input rnd_type rnd);
      logic [7:0] r;
      case (rnd)
         4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
         4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
         4'd9: r = 8'h1b; 4'd10: r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // byte i of a block sits at bits [127-8i -: 8]
   function automatic logic [7:0] get_byte(input blk_type b, input int i);
      return b[127 - 8*i -: 8];
   endfunction

   function automatic blk_type next_key(input blk_type k, input rnd_type rnd);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t = {sbox(w3[23:16]) ^ rcon(rnd), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   // SubBytes, ShiftRows and, unless final, MixColumns
   function automatic blk_type enc_round(input blk_type s, input logic final_rnd);
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, al;
      blk_type o;
      for (int c = 0; c < 4; c++)
         for (int j = 0; j < 4; j++)
            t[j + 4*c] = sbox(get_byte(s, j + 4*((c + j) & 3)));
      for (int c = 0; c < 4; c++) begin
         a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
         al = a0 ^ a1 ^ a2 ^ a3;
         if (!final_rnd) begin
            t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
            t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
            t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
            t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++)
         o[127 - 8*i -: 8] = t[i];
      return o;
   endfunction

   function automatic blk_type dbl(input blk_type v);
      return {v[126:0], 1'b0} ^ (v[127] ? {120'd0, CmacRb} : 128'd0);
   endfunction

endpackage

FILE: src/acmac_aes_lane.sv
// One AES-128 lane: one round per cycle, round keys expanded on the fly.
// Depends on acmac_pkg.
module acmac_aes_lane import acmac_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  blk_type din,
   input  blk_type key,
   output logic    done,
   output blk_type dout
);
   logic    busy_ff, busy_in;
   rnd_type rnd_ff, rnd_in;
   blk_type st_ff, st_in, rk_ff, rk_in, rk_nx;

   assign rk_nx = next_key(rk_ff, rnd_ff);

   always_comb begin
      busy_in = busy_ff;
      rnd_in  = rnd_ff;
      st_in   = st_ff;
      rk_in   = rk_ff;
      if (start) begin
         busy_in = 1'b1;
         rnd_in  = 4'd1;
         st_in   = din ^ key;
         rk_in   = key;
      end else if (busy_ff) begin
         st_in = enc_round(st_ff, rnd_ff == rnd_type'(NumRounds)) ^ rk_nx;
         rk_in = rk_nx;
         rnd_in = rnd_ff + 4'd1;
         if (rnd_ff == rnd_type'(NumRounds))
            busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rnd_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         rnd_ff  <= rnd_in;
      end
      st_ff <= st_in;
      rk_ff <= rk_in;
   end

   assign done = busy_ff && rnd_ff == rnd_type'(NumRounds);
   assign dout = st_in;
endmodule

FILE: src/acmac_merge.sv
// Merging stage: subkey derivation from L, padding and final-block XOR.
// Depends on acmac_pkg.
module acmac_merge import acmac_pkg::*; (
   input  blk_type     l_val,
   input  blk_type     chain,
   input  blk_type     blk,
   input  logic [4:0]  valid_bytes,
   input  logic        last_block,
   output blk_type     enc_in
);
   blk_type k1, k2, padded;
   logic full;

   assign k1   = dbl(l_val);
   assign k2   = dbl(k1);
   assign full = valid_bytes >= 5'd16;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         if (5'(i) < valid_bytes)
            padded[127 - 8*i -: 8] = blk[127 - 8*i -: 8];
         else if (5'(i) == valid_bytes)
            padded[127 - 8*i -: 8] = CmacPad;
         else
            padded[127 - 8*i -: 8] = 8'h00;
      end
      if (!last_block)
         enc_in = chain ^ blk;
      else if (full)
         enc_in = chain ^ blk ^ k1;
      else
         enc_in = chain ^ padded ^ k2;
   end
endmodule

FILE: src/aes128_cmac_generator_core.sv
// AES-128 CMAC top level: two AES lanes (L lane, data lane), merge, output reg.
// Depends on acmac_pkg, acmac_aes_lane, acmac_merge.
//
//  channel | ports                              | dir
//  req     | req_valid/ready, block, vb, last   | in
//  rsp     | rsp_valid/ready, mac_*, short_mac  | out
//  csr     | csr_we, csr_index, csr_wdata       | in
//
// A block that is not last: the data lane loads at accept and runs 10 rounds before
// the next accept. A first block runs the L lane, AES(K,0), beside it. A last block
// loads in the cycle after accept, in S_HOLD, from the registered merge; a one-block
// message first waits for L in S_LGEN.
// Synchronous active-high reset; a held result stalls only a last-block request.
module aes128_cmac_generator_core import acmac_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_block_high,
   input  logic [63:0] req_block_low,
   input  logic [4:0]  req_valid_bytes,
   input  logic        req_last_block,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_mac_high,
   output logic [63:0] rsp_mac_low,
   output logic [63:0] rsp_short_mac,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001, S_LGEN = 4'b0010, S_RUN = 4'b0100, S_HOLD = 4'b1000
   } st_type;

   st_type  st_ff, st_in;
   blk_type key_ff, chain_ff, l_ff, blk_ff;
   logic    mid_ff, last_ff;
   logic [4:0] vb_ff;
   logic    rv_ff;
   blk_type mac_ff;

   logic    l_start, l_done, d_start, d_done, acc;
   blk_type l_out, d_out, enc_in, chain_use;

   assign req_ready = st_ff == S_IDLE && !(rv_ff && !rsp_ready && req_last_block);
   assign acc       = req_valid && req_ready;

   // a new message starts from a zero chain
   assign chain_use = mid_ff ? chain_ff : '0;

   acmac_merge u_merge (
      .l_val(l_ff), .chain(chain_use), .blk(blk_ff),
      .valid_bytes(vb_ff), .last_block(last_ff), .enc_in(enc_in)
   );

   // first block: L lane runs; a non-last block runs in parallel.
   // S_HOLD is a one-cycle slot where the merge result from registered inputs
   // is launched; last blocks start there, not at accept.
   assign l_start = acc && !mid_ff;
   assign d_start = (acc && !req_last_block) || st_ff == S_HOLD;

   acmac_aes_lane u_lane_l (
      .clock, .reset, .start(l_start), .din('0), .key(key_ff),
      .done(l_done), .dout(l_out)
   );
   acmac_aes_lane u_lane_d (
      .clock, .reset, .start(d_start), .din(st_ff == S_IDLE ?
         ({req_block_high, req_block_low} ^ chain_use) : enc_in),
      .key(key_ff), .done(d_done), .dout(d_out)
   );

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         S_IDLE: if (acc) st_in = mid_ff ? (req_last_block ? S_HOLD : S_RUN) : S_LGEN;
         S_LGEN: if (l_done) st_in = last_ff ? S_HOLD : S_IDLE;
         S_RUN:  if (d_done) st_in = S_IDLE;
         S_HOLD: st_in = S_RUN;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= S_IDLE;
         key_ff   <= '0;
         chain_ff <= '0;
         mid_ff   <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (csr_we && !csr_index) key_ff[127:64] <= csr_wdata;
         if (csr_we &&  csr_index) key_ff[63:0]   <= csr_wdata;
         if (rv_ff && rsp_ready) rv_ff <= 1'b0;
         if (d_done) begin
            if (last_ff) begin
               rv_ff    <= 1'b1;
               chain_ff <= '0;
               mid_ff   <= 1'b0;
            end else begin
               chain_ff <= d_out;
               mid_ff   <= 1'b1;
            end
         end
      end
      if (acc) begin
         blk_ff  <= {req_block_high, req_block_low};
         vb_ff   <= req_valid_bytes;
         last_ff <= req_last_block;
      end
      if (l_done) l_ff <= l_out;
      if (d_done && last_ff) mac_ff <= d_out;
   end

   assign rsp_valid     = rv_ff;
   assign rsp_mac_high  = mac_ff[127:64];
   assign rsp_mac_low   = mac_ff[63:0];
   assign rsp_short_mac = {mac_ff[119:112], mac_ff[103:96], mac_ff[87:80], mac_ff[71:64],
                           mac_ff[55:48], mac_ff[39:32], mac_ff[23:16], mac_ff[7:0]};
endmodule

FILE: src/acmac_checker.sv
// Port-level checker for the CMAC core, bound to the top level.
// Depends on nothing but the top level's ports.
module acmac_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_last_block,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [63:0] rsp_mac_low
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mac_low))
      else $error("response dropped or changed while stalled");
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");
   a_last_no_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_block |=> !rsp_valid || $past(rsp_valid))
      else $error("response before encryption done");
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind aes128_cmac_generator_core acmac_checker u_chk (.*);

FILE: bench/tb_aes128_cmac_generator_core.sv
// Self-checking bench for the AES-128 CMAC core: random and directed messages,
// results checked against an in-bench CMAC computation. Depends on acmac_pkg.
module tb_aes128_cmac_generator_core;
   import acmac_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam bit KeyHighIdx = 1'b0;
   localparam bit KeyLowIdx  = 1'b1;
   localparam int DrainCycles = 40;

   typedef struct {
      logic [63:0] hi;
      logic [63:0] lo;
      logic [4:0]  vb;
      logic        last;
   } msg_block_type;

   typedef struct {
      logic [63:0] mac_hi;
      logic [63:0] mac_lo;
      logic [63:0] short_mac;
   } mac_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [63:0] req_block_high = '0;
   logic [63:0] req_block_low = '0;
   logic [4:0]  req_valid_bytes = '0;
   logic        req_last_block = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [63:0] rsp_mac_high, rsp_mac_low, rsp_short_mac;
   logic        csr_we = 0;
   logic        csr_index = 0;
   logic [63:0] csr_wdata = '0;

   aes128_cmac_generator_core dut (.*);

   always #2 clock = ~clock;

   msg_block_type pending_blocks[$];
   mac_type       expected_macs[$];
   int            errors = 0;

   // bench copy of the core's state
   logic [127:0] cur_key = '0;
   logic [127:0] chain_acc = '0;
   logic [127:0] l_value = '0;
   logic         msg_open = 0;
   logic [7:0]   sub_tab[256];

   function automatic logic [7:0] gf_x2(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = gf_x2(a);
      end
      return p;
   endfunction

   // S-box from the field inverse and the affine map
   function automatic void build_sub_tab();
      logic [7:0] inv, b;
      for (int x = 0; x < 256; x++) begin
         inv = 0;
         for (int y = 1; y < 256; y++)
            if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
         b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
         sub_tab[x] = b;
      end
   endfunction

   function automatic logic [127:0] aes128_encrypt(input logic [127:0] key,
                                                   input logic [127:0] pt);
      logic [127:0] s, rk;
      logic [7:0]   t[16];
      logic [7:0]   a0, a1, a2, a3, rc;
      logic [31:0]  w3, g;
      rk = key;
      s = pt ^ rk;
      rc = 8'h01;
      for (int r = 1; r <= 10; r++) begin
         w3 = rk[31:0];
         g = {sub_tab[w3[23:16]] ^ rc, sub_tab[w3[15:8]], sub_tab[w3[7:0]],
              sub_tab[w3[31:24]]};
         rk[127:96] ^= g;
         rk[95:64]  ^= rk[127:96];
         rk[63:32]  ^= rk[95:64];
         rk[31:0]   ^= rk[63:32];
         rc = gf_x2(rc);
         for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++)
               t[j + 4*c] = sub_tab[s[127 - 8*(j + 4*((c + j) & 3)) -: 8]];
         if (r != 10)
            for (int c = 0; c < 4; c++) begin
               a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
               t[4*c]   = gf_x2(a0) ^ gf_x2(a1) ^ a1 ^ a2 ^ a3;
               t[4*c+1] = a0 ^ gf_x2(a1) ^ gf_x2(a2) ^ a2 ^ a3;
               t[4*c+2] = a0 ^ a1 ^ gf_x2(a2) ^ gf_x2(a3) ^ a3;
               t[4*c+3] = gf_x2(a0) ^ a0 ^ a1 ^ a2 ^ gf_x2(a3);
            end
         for (int i = 0; i < 16; i++) s[127 - 8*i -: 8] = t[i];
         s ^= rk;
      end
      return s;
   endfunction

   function automatic logic [127:0] gf128_double(input logic [127:0] v);
      return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
   endfunction

   // advance the CMAC state by one accepted block; queue the MAC on a last block
   function automatic void cmac_absorb(input msg_block_type b);
      logic [127:0] blk, sub, mac;
      int nb;
      mac_type m;
      blk = {b.hi, b.lo};
      if (!msg_open) begin
         l_value = aes128_encrypt(cur_key, '0);
         chain_acc = '0;
      end
      if (!b.last) begin
         chain_acc = aes128_encrypt(cur_key, chain_acc ^ blk);
         msg_open = 1;
         return;
      end
      nb = (b.vb > 16) ? 16 : int'(b.vb);
      sub = gf128_double(l_value);
      if (nb < 16) begin
         for (int i = nb; i < 16; i++) blk[127 - 8*i -: 8] = 8'h00;
         blk[127 - 8*nb -: 8] = 8'h80;
         sub = gf128_double(sub);
      end
      mac = aes128_encrypt(cur_key, chain_acc ^ blk ^ sub);
      m.mac_hi = mac[127:64];
      m.mac_lo = mac[63:0];
      for (int i = 0; i < 8; i++) m.short_mac[63 - 8*i -: 8] = mac[127 - 8*(2*i + 1) -: 8];
      expected_macs.push_back(m);
      chain_acc = '0;
      msg_open = 0;
   endfunction

   // request driver: bursts with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      msg_block_type nb;
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && req_ready) cmac_absorb('{req_block_high, req_block_low,
                                                  req_valid_bytes, req_last_block});
         if (!(req_valid && !req_ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 0;
            end else if (pending_blocks.size() > 0) begin
               nb = pending_blocks.pop_front();
               req_block_high  <= nb.hi;
               req_block_low   <= nb.lo;
               req_valid_bytes <= nb.vb;
               req_last_block  <= nb.last;
               req_valid <= 1;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // response monitor with its own stall pattern and one long hold-off
   int macs_seen = 0;
   int hold_left = 0;
   bit hold_done = 0;
   int stall_mode = 0;
   always @(posedge clock) begin
      mac_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            macs_seen++;
            if (expected_macs.size() == 0) begin
               $display("%0t: unexpected response mac %h_%h", $time, rsp_mac_high, rsp_mac_low);
               errors++;
            end else begin
               e = expected_macs.pop_front();
               if (rsp_mac_high !== e.mac_hi) begin
                  $display("%0t: mac_high exp %h got %h", $time, e.mac_hi, rsp_mac_high);
                  errors++;
               end
               if (rsp_mac_low !== e.mac_lo) begin
                  $display("%0t: mac_low exp %h got %h", $time, e.mac_lo, rsp_mac_low);
                  errors++;
               end
               if (rsp_short_mac !== e.short_mac) begin
                  $display("%0t: short_mac exp %h got %h", $time, e.short_mac, rsp_short_mac);
                  errors++;
               end
            end
         end
         if (!hold_done && macs_seen == 30) begin
            hold_done = 1;
            hold_left = 600;
         end
         if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 0;
         end else begin
            case (stall_mode)
               0: rsp_ready <= 1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   function automatic logic [63:0] rand64();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic void add_block(input logic [63:0] hi, input logic [63:0] lo,
                                     input logic [4:0] vb, input logic last);
      msg_block_type b;
      b = '{hi, lo, vb, last};
      pending_blocks.push_back(b);
   endfunction

   function automatic void add_random_message();
      int nfull;
      logic [4:0] vb;
      nfull = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(0, 3);
      for (int i = 0; i < nfull; i++) add_block(rand64(), rand64(), 5'($urandom), 0);
      case ($urandom_range(0, 5))
         0: vb = 5'd16;
         1: vb = 5'($urandom_range(17, 31));
         2: vb = 5'd0;
         default: vb = 5'($urandom_range(1, 15));
      endcase
      add_block(rand64(), rand64(), vb, 1);
   endfunction

   task automatic wait_idle();
      while (pending_blocks.size() > 0 || req_valid || expected_macs.size() > 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_key(input logic [127:0] k);
      @(posedge clock);
      csr_we <= 1; csr_index <= KeyHighIdx; csr_wdata <= k[127:64];
      @(posedge clock);
      csr_index <= KeyLowIdx; csr_wdata <= k[63:0];
      @(posedge clock);
      csr_we <= 0;
      cur_key = k;
   endtask

   initial begin
      logic [127:0] keys[6];
      build_sub_tab();
      keys[0] = 128'h2b7e151628aed2a6abf7158809cf4f3c;
      keys[1] = '1;
      keys[2] = '0;
      keys[3] = {$urandom, $urandom, $urandom, $urandom};
      keys[4] = 128'h8000_0000_0000_0000_0000_0000_0000_0001;
      keys[5] = {$urandom, $urandom, $urandom, $urandom};
      repeat (3) @(posedge clock);
      reset <= 0;
      for (int p = 0; p < 6; p++) begin
         write_key(keys[p]);
         if (p == 0) begin
            // empty message, complete block, saturated count, partial blocks
            add_block('0, '0, 5'd0, 1);
            add_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1);
            add_block('1, '1, 5'd31, 1);
            add_block('1, '1, 5'd17, 1);
            add_block('1, '1, 5'd15, 1);
            add_block('1, '1, 5'd1, 1);
            add_block('1, '1, 5'd8, 1);
            // multi-block message; count on inner blocks is ignored
            add_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd0, 0);
            add_block(64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 5'd31, 0);
            add_block(64'h30c81c46a35ce411, 64'he5fbc1191a0a52ef, 5'd8, 1);
            add_block('0, '1, 5'd3, 0);
            add_block('1, '0, 5'd0, 1);
            add_block(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd4, 1);
         end
         while (pending_blocks.size() < 325) add_random_message();
         wait_idle();
      end
      if (expected_macs.size() != 0) errors++;
      if (errors == 0)
         $display("aes128_cmac_generator_core: match");
      else
         $display("aes128_cmac_generator_core: mismatch");
      $finish;
   end

   initial begin
      #20ms;
      $display("aes128_cmac_generator_core: mismatch");
      $finish;
   end

endmodule
